// ===== rtl/ttopk_pkg.sv =====
// ----------------------------------------------------------------------------
// ttopk_pkg
// Types, codes and sizes shared by the telemetry top-k record table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttopk_pkg;

  localparam int MAX_ENTRIES = 4;
  localparam int SLOT_W      = 2;
  localparam int FILL_W      = 3;
  localparam int ADDR_W      = SLOT_W + 1;
  localparam int DIV_STEPS   = 16;
  localparam int CNT_W       = 4;

  typedef enum logic [2:0] {
    FN_PUSH_DEPTH = 3'd0,
    FN_PUSH_RATIO = 3'd1,
    FN_READ_DEPTH = 3'd2,
    FN_READ_RATIO = 3'd3,
    FN_CLEAR      = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    STS_STORED  = 2'd0,
    STS_DISCARD = 2'd1,
    STS_REJECT  = 2'd2,
    STS_DONE    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_FILL,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_WRITE,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  node_id;
    logic [7:0]  port_num;
    logic [15:0] metric;
    logic [31:0] stamp;
    logic [7:0]  line_rate;
    logic [1:0]  read_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        slot;
    logic [7:0]        out_node_id;
    logic [7:0]        out_port_num;
    logic [15:0]       out_metric;
    logic [31:0]       out_stamp;
    logic [7:0]        out_line_rate;
    logic              out_valid;
    logic [FILL_W-1:0] depth_fill;
    logic [FILL_W-1:0] ratio_fill;
  } out_item_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] value;
    logic [31:0] stamp;
    logic [7:0]  rate;
  } entry_t;

  typedef struct packed {
    logic              load;
    logic              div_step;
    logic              scan_rd;
    logic              rd_req;
    logic              wr;
    logic              clear;
    logic              emit;
    logic              set_status;
    status_t           status;
    logic [SLOT_W-1:0] idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       reject;
    logic       full;
    logic       gt_min;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ttopk_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttopk_ctrl
// Sequencer: divide, fill check, minimum scan, write, read or clear, then result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttopk_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire ttopk_pkg::dp_stat_t stat,
  output ttopk_pkg::ctl_cmd_t      cmd,
  output logic                     busy
);

  ttopk_pkg::state_t                 state_r, state_nxt;
  logic [ttopk_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttopk_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // held busy during reset so nothing is taken then
  assign busy = !rst_n || (state_r != ttopk_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.status = ttopk_pkg::STS_DONE;
    cmd.idx    = cnt_r[ttopk_pkg::SLOT_W-1:0];
    unique case (state_r)
      ttopk_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ttopk_pkg::S_DECODE;
        end
      end
      ttopk_pkg::S_DECODE: begin
        cnt_nxt = '0;
        unique case (stat.func)
          ttopk_pkg::FN_PUSH_DEPTH: state_nxt = ttopk_pkg::S_DIV;
          ttopk_pkg::FN_PUSH_RATIO: state_nxt = ttopk_pkg::S_FILL;
          ttopk_pkg::FN_READ_DEPTH,
          ttopk_pkg::FN_READ_RATIO: state_nxt = ttopk_pkg::S_READ;
          ttopk_pkg::FN_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = ttopk_pkg::S_DONE;
          end
          default: state_nxt = ttopk_pkg::S_DONE;
        endcase
      end
      ttopk_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == ttopk_pkg::CNT_W'(ttopk_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ttopk_pkg::S_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ttopk_pkg::S_FILL: begin
        cnt_nxt = '0;
        priority if (stat.reject) begin
          cmd.set_status = 1'b1;
          cmd.status     = ttopk_pkg::STS_REJECT;
          state_nxt      = ttopk_pkg::S_DONE;
        end else if (!stat.full) begin
          state_nxt = ttopk_pkg::S_WRITE;
        end else begin
          state_nxt = ttopk_pkg::S_SCAN;
        end
      end
      ttopk_pkg::S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (cnt_r == ttopk_pkg::CNT_W'(ttopk_pkg::MAX_ENTRIES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ttopk_pkg::S_SCAN_END;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ttopk_pkg::S_SCAN_END: state_nxt = ttopk_pkg::S_DECIDE;
      ttopk_pkg::S_DECIDE: begin
        if (stat.gt_min) begin
          state_nxt = ttopk_pkg::S_WRITE;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = ttopk_pkg::STS_DISCARD;
          state_nxt      = ttopk_pkg::S_DONE;
        end
      end
      ttopk_pkg::S_WRITE: begin
        cmd.wr         = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = ttopk_pkg::STS_STORED;
        state_nxt      = ttopk_pkg::S_DONE;
      end
      ttopk_pkg::S_READ: begin
        cmd.rd_req = 1'b1;
        state_nxt  = ttopk_pkg::S_DONE;
      end
      ttopk_pkg::S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = ttopk_pkg::S_IDLE;
      end
      default: state_nxt = ttopk_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ttopk_dp.sv =====
// ----------------------------------------------------------------------------
// ttopk_dp
// Datapath: item register, restoring divider, entry memory, min tracker,
// fill counts and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttopk_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ttopk_pkg::in_item_t in_item,
  input  wire ttopk_pkg::ctl_cmd_t cmd,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_data,
  output ttopk_pkg::dp_stat_t      stat,
  output ttopk_pkg::out_item_t     out_item,
  output logic                     out_strobe
);

  localparam int DEPTH = 2 * ttopk_pkg::MAX_ENTRIES;

  ttopk_pkg::in_item_t              item_r;
  logic [15:0]                      unit_r;
  logic [15:0]                      rem_r;
  logic [15:0]                      q_r;
  logic [ttopk_pkg::FILL_W-1:0]     dcnt_r;
  logic [ttopk_pkg::FILL_W-1:0]     rcnt_r;
  ttopk_pkg::entry_t                mem_r [DEPTH];
  ttopk_pkg::entry_t                rd_data_r;
  logic                             cmp_en_r;
  logic [ttopk_pkg::SLOT_W-1:0]     cmp_idx_r;
  logic [15:0]                      min_r;
  logic [ttopk_pkg::SLOT_W-1:0]     min_idx_r;
  ttopk_pkg::status_t               res_status_r;
  logic [ttopk_pkg::SLOT_W-1:0]     res_slot_r;
  ttopk_pkg::out_item_t             out_r, out_nxt;
  logic                             out_stb_r;

  logic                             is_ratio;
  logic                             is_read;
  logic [ttopk_pkg::FILL_W-1:0]     tab_cnt;
  logic                             full;
  logic [ttopk_pkg::SLOT_W-1:0]     widx;
  logic [ttopk_pkg::SLOT_W-1:0]     rd_idx;
  logic [ttopk_pkg::ADDR_W-1:0]     rd_addr;
  logic [ttopk_pkg::ADDR_W-1:0]     wr_addr;
  logic [16:0]                      sh;
  logic [17:0]                      diff;
  logic                             ge;
  logic                             rd_ok;
  ttopk_pkg::entry_t                wr_entry;

  assign is_ratio = (item_r.func == ttopk_pkg::FN_PUSH_RATIO) ||
                    (item_r.func == ttopk_pkg::FN_READ_RATIO);
  assign is_read  = (item_r.func == ttopk_pkg::FN_READ_DEPTH) ||
                    (item_r.func == ttopk_pkg::FN_READ_RATIO);
  assign tab_cnt  = is_ratio ? rcnt_r : dcnt_r;
  assign full     = (tab_cnt >= ttopk_pkg::FILL_W'(ttopk_pkg::MAX_ENTRIES));
  assign widx     = full ? min_idx_r : tab_cnt[ttopk_pkg::SLOT_W-1:0];
  assign rd_idx   = cmd.scan_rd ? cmd.idx : item_r.read_slot[ttopk_pkg::SLOT_W-1:0];
  assign rd_addr  = {is_ratio, rd_idx};
  assign wr_addr  = {is_ratio, widx};

  // one quotient bit per step; a zero divisor yields all ones
  assign sh   = {rem_r, q_r[15]};
  assign diff = {1'b0, sh} - {2'b00, unit_r};
  assign ge   = ~diff[17];

  assign stat.func   = item_r.func;
  assign stat.reject = (item_r.func == ttopk_pkg::FN_PUSH_DEPTH) && (q_r == 16'd0);
  assign stat.full   = full;
  assign stat.gt_min = (q_r > min_r);

  assign wr_entry.key   = {item_r.node_id, item_r.port_num};
  assign wr_entry.value = q_r;
  assign wr_entry.stamp = item_r.stamp;
  assign wr_entry.rate  = item_r.line_rate;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r <= 16'd1;
    end else if (cfg_we) begin
      unit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      q_r    <= in_item.metric;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[15:0] : sh[15:0];
      q_r   <= {q_r[14:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_r[wr_addr] <= wr_entry;
    end
    if (cmd.scan_rd || cmd.rd_req) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmd.idx;
    if (cmp_en_r && ((cmp_idx_r == '0) || (rd_data_r.value < min_r))) begin
      min_r     <= rd_data_r.value;
      min_idx_r <= cmp_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
      rcnt_r <= '0;
    end else if (cmd.clear) begin
      dcnt_r <= '0;
      rcnt_r <= '0;
    end else if (cmd.wr && !full) begin
      if (is_ratio) begin
        rcnt_r <= rcnt_r + 1'b1;
      end else begin
        dcnt_r <= dcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status_r <= ttopk_pkg::STS_DONE;
      res_slot_r   <= ((in_item.func == ttopk_pkg::FN_READ_DEPTH) ||
                       (in_item.func == ttopk_pkg::FN_READ_RATIO)) ?
                      in_item.read_slot[ttopk_pkg::SLOT_W-1:0] : '0;
    end else begin
      if (cmd.set_status) begin
        res_status_r <= cmd.status;
      end
      if (cmd.wr) begin
        res_slot_r <= widx;
      end
    end
  end

  assign rd_ok = is_read && ({1'b0, res_slot_r} < tab_cnt);

  always_comb begin
    out_nxt            = '0;
    out_nxt.status     = res_status_r;
    out_nxt.slot       = 2'(res_slot_r);
    out_nxt.depth_fill = dcnt_r;
    out_nxt.ratio_fill = rcnt_r;
    if (rd_ok) begin
      out_nxt.out_node_id   = rd_data_r.key[15:8];
      out_nxt.out_port_num  = rd_data_r.key[7:0];
      out_nxt.out_metric    = rd_data_r.value;
      out_nxt.out_stamp     = rd_data_r.stamp;
      out_nxt.out_line_rate = rd_data_r.rate;
      out_nxt.out_valid     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_stb_r <= 1'b0;
    end else begin
      out_stb_r <= cmd.emit;
    end
  end

  assign out_item   = out_r;
  assign out_strobe = out_stb_r;

endmodule

`default_nettype wire

// ===== rtl/telemetry_topk_record_table_core.sv =====
// ----------------------------------------------------------------------------
// telemetry_topk_record_table_core
// Two top-k telemetry record tables (queue depth, rate ratio) with
// min-replacement once full.
// ----------------------------------------------------------------------------
// channel   | ports                          | handshake
// input     | start, busy, in_item           | taken when start && !busy
// result    | out_strobe, out_item           | one-cycle strobe, no backpressure
// config    | cfg_valid, cfg_ready, cfg_data | taken when cfg_valid && cfg_ready
//
// One item at a time. From accept to result strobe, a depth push runs the
// 16 divider steps, then the fill check, which rejects a zero quotient; when
// the table is full, a 4-entry min scan through the single read port of the
// entry memory picks store or discard. Only depth pushes divide and only
// pushes to a full table scan. busy falls in the strobe cycle.
// Synchronous reset clears the counts and sets qlen_unit to 1; no clear pass.
// busy stays high while in reset; config is not taken in a start cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module telemetry_topk_record_table_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ttopk_pkg::in_item_t  in_item,
  output logic                      out_strobe,
  output ttopk_pkg::out_item_t      out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [15:0]          cfg_data
);

  ttopk_pkg::ctl_cmd_t cmd;
  ttopk_pkg::dp_stat_t stat;
  logic                busy_w;

  assign busy      = busy_w;
  assign cfg_ready = ~busy_w & ~start;

  ttopk_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy_w)
  );

  ttopk_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .stat       (stat),
    .out_item   (out_item),
    .out_strobe (out_strobe)
  );

endmodule

`default_nettype wire

// ===== rtl/ttopk_chk.sv =====
// ----------------------------------------------------------------------------
// ttopk_chk
// Port-level checks for the top-k record table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttopk_chk (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_strobe,
  input wire ttopk_pkg::out_item_t out_item,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result strobes");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.depth_fill <= 3'(ttopk_pkg::MAX_ENTRIES)) &&
                   (out_item.ratio_fill <= 3'(ttopk_pkg::MAX_ENTRIES)))
    else $error("fill count beyond table size");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> !busy)
    else $error("config taken while busy");

endmodule

bind telemetry_topk_record_table_core ttopk_chk u_ttopk_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives push, read, clear and unused command codes into the two top-k
// record tables. A local copy of both tables predicts each reply, and every
// reply is checked field by field in order. qlen_unit is changed between
// phases, and the gaps between commands differ from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ttopk_pkg::*;

  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 158;
  localparam int DEPTH_TAB       = 0;
  localparam int RATIO_TAB       = 1;
  localparam logic [15:0] DEPTH_CAP    = 16'hffff;
  localparam logic [2:0]  FN_UNUSED_LO = 3'd5;
  localparam logic [2:0]  FN_UNUSED_HI = 3'd7;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_strobe;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  in_item_t    cmd_q[$];
  out_item_t   reply_q[$];
  int          idle_pct = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  // local copy of the block state
  logic [15:0]       qlen_unit = 16'd1;
  logic [FILL_W-1:0] tab_fill[2] = '{default: '0};
  entry_t            tab_ent[2][MAX_ENTRIES];

  telemetry_topk_record_table_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t table_reply(input in_item_t cmd);
    out_item_t   r;
    int          t;
    int          victim;
    logic [15:0] val;
    r = '0;
    r.status = STS_DONE;
    case (cmd.func)
      FN_PUSH_DEPTH, FN_PUSH_RATIO: begin
        t = (cmd.func == FN_PUSH_DEPTH) ? DEPTH_TAB : RATIO_TAB;
        if (t == DEPTH_TAB)
          val = (qlen_unit == '0) ? DEPTH_CAP : cmd.metric / qlen_unit;
        else
          val = cmd.metric;
        if (t == DEPTH_TAB && val == '0) begin
          r.status = STS_REJECT;
        end else begin
          victim = int'(tab_fill[t]);
          if (tab_fill[t] < MAX_ENTRIES) begin
            tab_fill[t] = tab_fill[t] + 1'b1;
          end else begin
            // first entry holding the smallest value
            victim = 0;
            for (int i = 1; i < MAX_ENTRIES; i++)
              if (tab_ent[t][i].value < tab_ent[t][victim].value) victim = i;
            if (val <= tab_ent[t][victim].value) victim = -1;
          end
          if (victim < 0) begin
            r.status = STS_DISCARD;
          end else begin
            tab_ent[t][victim] = '{key: {cmd.node_id, cmd.port_num}, value: val,
                                   stamp: cmd.stamp, rate: cmd.line_rate};
            r.status = STS_STORED;
            r.slot   = victim[SLOT_W-1:0];
          end
        end
      end
      FN_READ_DEPTH, FN_READ_RATIO: begin
        t = (cmd.func == FN_READ_DEPTH) ? DEPTH_TAB : RATIO_TAB;
        r.slot = cmd.read_slot;
        if (cmd.read_slot < tab_fill[t]) begin
          r.out_node_id   = tab_ent[t][cmd.read_slot].key[15:8];
          r.out_port_num  = tab_ent[t][cmd.read_slot].key[7:0];
          r.out_metric    = tab_ent[t][cmd.read_slot].value;
          r.out_stamp     = tab_ent[t][cmd.read_slot].stamp;
          r.out_line_rate = tab_ent[t][cmd.read_slot].rate;
          r.out_valid     = 1'b1;
        end
      end
      FN_CLEAR: begin
        tab_fill[DEPTH_TAB] = '0;
        tab_fill[RATIO_TAB] = '0;
      end
      default: ;
    endcase
    r.depth_fill = tab_fill[DEPTH_TAB];
    r.ratio_fill = tab_fill[RATIO_TAB];
    return r;
  endfunction

  function automatic in_item_t table_cmd(input logic [2:0] func, input logic [7:0] node,
                                         input logic [7:0] port, input logic [15:0] metric,
                                         input logic [31:0] stamp, input logic [7:0] rate,
                                         input logic [1:0] rd_slot);
    return '{func: func, node_id: node, port_num: port, metric: metric, stamp: stamp,
             line_rate: rate, read_slot: rd_slot};
  endfunction

  function automatic in_item_t rand_cmd();
    in_item_t c;
    int       pick;
    c.node_id   = 8'($urandom);
    c.port_num  = 8'($urandom);
    c.metric    = 16'($urandom);
    c.stamp     = $urandom;
    c.line_rate = 8'($urandom);
    c.read_slot = 2'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 36)      c.func = FN_PUSH_DEPTH;
    else if (pick < 68) c.func = FN_PUSH_RATIO;
    else if (pick < 80) c.func = FN_READ_DEPTH;
    else if (pick < 92) c.func = FN_READ_RATIO;
    else if (pick < 95) c.func = FN_CLEAR;
    else                c.func = 3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
    // small values give ties and near misses at the minimum
    case ($urandom_range(0, 2))
      0: c.metric = 16'($urandom_range(0, 24));
      1: c.metric = 16'(qlen_unit * $urandom_range(0, 24));
      default: ;
    endcase
    return c;
  endfunction

  task automatic write_qlen_unit(input logic [15:0] unit);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= unit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    qlen_unit = unit;
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || start || reply_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // command driver and reply prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) reply_q.push_back(table_reply(in_item));
      if (!start || !busy) begin
        if (cmd_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          start   <= 1'b1;
          in_item <= cmd_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : reply_check
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (reply_q.size() == 0) begin
        $error("reply with no command pending");
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        check_field("status", want.status, out_item.status);
        check_field("slot", want.slot, out_item.slot);
        check_field("out_node_id", want.out_node_id, out_item.out_node_id);
        check_field("out_port_num", want.out_port_num, out_item.out_port_num);
        check_field("out_metric", want.out_metric, out_item.out_metric);
        check_field("out_stamp", want.out_stamp, out_item.out_stamp);
        check_field("out_line_rate", want.out_line_rate, out_item.out_line_rate);
        check_field("out_valid", want.out_valid, out_item.out_valid);
        check_field("depth_fill", want.depth_fill, out_item.depth_fill);
        check_field("ratio_fill", want.ratio_fill, out_item.ratio_fill);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] unit;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset value of qlen_unit: empty reads, reject, fill, discard, replace, ratio table, unused codes, clear
    @(negedge clk);
    cmd_q.push_back(table_cmd(FN_READ_DEPTH, 8'h00, 8'h00, 16'h0000, 32'h0, 8'h00, 2'd0));
    cmd_q.push_back(table_cmd(FN_READ_RATIO, 8'h00, 8'h00, 16'h0000, 32'h0, 8'h00, 2'd3));
    cmd_q.push_back(table_cmd(FN_PUSH_DEPTH, 8'h12, 8'h34, 16'h0000, 32'h1, 8'h01, 2'd0));
    cmd_q.push_back(table_cmd(FN_PUSH_DEPTH, 8'hff, 8'hff, 16'hffff, 32'hffffffff,
                              8'hff, 2'd3));
    cmd_q.push_back(table_cmd(FN_PUSH_DEPTH, 8'h00, 8'h00, 16'h0001, 32'h0, 8'h00, 2'd0));
    cmd_q.push_back(table_cmd(FN_PUSH_DEPTH, 8'h01, 8'h02, 16'h0002, 32'h10, 8'h20, 2'd1));
    cmd_q.push_back(table_cmd(FN_PUSH_DEPTH, 8'h03, 8'h04, 16'h0005, 32'h30, 8'h40, 2'd2));
    cmd_q.push_back(table_cmd(FN_PUSH_DEPTH, 8'haa, 8'h55, 16'h0001, 32'h5, 8'h06, 2'd0));
    cmd_q.push_back(table_cmd(FN_PUSH_DEPTH, 8'h55, 8'haa, 16'h0003, 32'h7, 8'h08, 2'd0));
    cmd_q.push_back(table_cmd(FN_PUSH_RATIO, 8'h80, 8'h01, 16'h0000, 32'h9, 8'h0a, 2'd0));
    cmd_q.push_back(table_cmd(FN_PUSH_RATIO, 8'hff, 8'hff, 16'hffff, 32'hffffffff,
                              8'hff, 2'd0));
    cmd_q.push_back(table_cmd(FN_PUSH_RATIO, 8'h07, 8'h07, 16'h0007, 32'h70, 8'h77, 2'd0));
    cmd_q.push_back(table_cmd(FN_PUSH_RATIO, 8'h08, 8'h08, 16'h0007, 32'h80, 8'h88, 2'd0));
    cmd_q.push_back(table_cmd(FN_PUSH_RATIO, 8'h09, 8'h09, 16'h0000, 32'h90, 8'h99, 2'd0));
    cmd_q.push_back(table_cmd(FN_READ_DEPTH, 8'h00, 8'h00, 16'h0000, 32'h0, 8'h00, 2'd1));
    cmd_q.push_back(table_cmd(FN_READ_RATIO, 8'h00, 8'h00, 16'h0000, 32'h0, 8'h00, 2'd1));
    cmd_q.push_back(table_cmd(FN_UNUSED_LO, 8'hff, 8'hff, 16'hffff, 32'hffffffff,
                              8'hff, 2'd3));
    cmd_q.push_back(table_cmd(FN_UNUSED_HI, 8'h00, 8'h00, 16'h0000, 32'h0, 8'h00, 2'd0));
    cmd_q.push_back(table_cmd(FN_CLEAR, 8'h00, 8'h00, 16'h0000, 32'h0, 8'h00, 2'd0));
    cmd_q.push_back(table_cmd(FN_READ_DEPTH, 8'h00, 8'h00, 16'h0000, 32'h0, 8'h00, 2'd0));
    drain();

    // largest divisor: only a full-scale depth survives quantization
    write_qlen_unit(16'hffff);
    @(negedge clk);
    cmd_q.push_back(table_cmd(FN_PUSH_DEPTH, 8'h11, 8'h22, 16'hffff, 32'h1, 8'h02, 2'd0));
    cmd_q.push_back(table_cmd(FN_PUSH_DEPTH, 8'h33, 8'h44, 16'hfffe, 32'h3, 8'h04, 2'd0));
    drain();

    // zero divisor saturates the quotient
    write_qlen_unit(16'h0000);
    @(negedge clk);
    cmd_q.push_back(table_cmd(FN_PUSH_DEPTH, 8'h5a, 8'ha5, 16'h0000, 32'h2, 8'h03, 2'd0));
    cmd_q.push_back(table_cmd(FN_READ_DEPTH, 8'h00, 8'h00, 16'h0000, 32'h0, 8'h00, 2'd1));
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: unit = 16'd1;
        1: unit = 16'($urandom_range(2, 16));
        2: unit = 16'hffff;
        3: unit = 16'h0000;
        4: unit = 16'($urandom);
        default: unit = 16'($urandom_range(2, 300));
      endcase
      write_qlen_unit(unit);
      @(negedge clk);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 48;
        default: idle_pct = 16;
      endcase
      repeat (ITEMS_PER_PHASE) cmd_q.push_back(rand_cmd());
      drain();
    end

    if (mismatches == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
